// ===== rtl/blsu_pkg.sv =====
// shared constants and types for the byte addressed load/store unit
`default_nettype none

package blsu_pkg;

    // size of the word store, split over an even and an odd bank
    localparam int unsigned MEM_WORDS       = 4096;
    localparam int unsigned BANK_EVEN_DEPTH = (MEM_WORDS + 1) / 2;
    localparam int unsigned BANK_ODD_DEPTH  = MEM_WORDS / 2;
    localparam int unsigned BANK_AW         =
        (BANK_EVEN_DEPTH > 1) ? $clog2(BANK_EVEN_DEPTH) : 1;

    // stream payload widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 40;

    typedef enum logic [2:0] {
        OP_LB  = 3'd0,
        OP_LH  = 3'd1,
        OP_LW  = 3'd2,
        OP_LBU = 3'd3,
        OP_LHU = 3'd4,
        OP_SB  = 3'd5,
        OP_SH  = 3'd6,
        OP_SW  = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/byte_addressed_load_store_unit.sv =====
// result: accept captures the access and reads both banks, then execute registers the result word
// order: a new word is taken only in idle, once execute is done with the last one; the accept reads
//   both banks, then execute modifies and writes them back (even/odd banks let a split access touch both words at once)
// stalls: a result word still waiting on m_tready holds the access in execute
// reset: rst_n clears control state, then a clearing pass zeroes the store one row of both
//   banks per cycle, with s_tready held low
`default_nettype none

module byte_addressed_load_store_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // operation [2:0], address [34:3], store_data [66:35], zero [71:67]
    input  wire logic [blsu_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // load_data [31:0], access_error [32], zero [39:33]
    output logic      [blsu_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int unsigned AW = blsu_pkg::BANK_AW;

    blsu_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;

    // captured access
    blsu_pkg::op_t    op_reg;
    logic [1:0]       lane_reg;
    logic             odd_first_reg;
    logic             split_reg;
    logic             err_reg;
    logic [31:0]      sdata_reg;
    logic [AW-1:0]    addr_even_reg;
    logic [AW-1:0]    addr_odd_reg;

    logic [31:0]      mem_even [blsu_pkg::BANK_EVEN_DEPTH];
    logic [31:0]      mem_odd  [blsu_pkg::BANK_ODD_DEPTH];
    logic [31:0]      rd_even_reg;
    logic [31:0]      rd_odd_reg;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [blsu_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // input decode
    blsu_pkg::op_t in_op;
    logic [31:0]   in_addr;
    logic [31:0]   in_sdata;
    logic [29:0]   in_idx;
    logic [1:0]    in_lane;
    logic          in_split;
    logic          in_err;
    logic [AW-1:0] in_base;
    logic [AW-1:0] in_addr_even;
    logic          accept;

    // execute
    logic          out_free;
    logic          is_store;
    logic [63:0]   pair;
    logic [63:0]   wmask;
    logic [5:0]    shamt;
    logic [63:0]   shifted;
    logic [63:0]   new_pair;
    logic [31:0]   load_val;

    // bank write side
    logic          we_even, we_odd;
    logic [AW-1:0] wa_even, wa_odd;
    logic [31:0]   wd_even, wd_odd;

    assign in_op    = blsu_pkg::op_t'(s_tdata[2:0]);
    assign in_addr  = s_tdata[34:3];
    assign in_sdata = s_tdata[66:35];
    assign in_idx   = in_addr[31:2];
    assign in_lane  = in_addr[1:0];

    always_comb
    begin
        unique case (in_op)
            blsu_pkg::OP_LB, blsu_pkg::OP_LBU, blsu_pkg::OP_SB: in_split = 1'b0;
            blsu_pkg::OP_LH, blsu_pkg::OP_LHU, blsu_pkg::OP_SH: in_split = (in_lane == 2'd3);
            default:                                            in_split = (in_lane != 2'd0);
        endcase
    end

    assign in_err = (in_idx >= 30'(blsu_pkg::MEM_WORDS)) ||
                    (in_split && (({1'b0, in_idx} + 31'd1) >= 31'(blsu_pkg::MEM_WORDS)));

    // word idx0 and idx0+1 always sit in opposite banks
    assign in_base      = in_idx[AW:1];
    assign in_addr_even = in_idx[0] ? in_base + AW'(1) : in_base;

    assign s_tready = (state_reg == blsu_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign is_store = (op_reg == blsu_pkg::OP_SB) || (op_reg == blsu_pkg::OP_SH) ||
                      (op_reg == blsu_pkg::OP_SW);

    // low word of the pair is always the word at idx0
    assign pair  = odd_first_reg ? {rd_even_reg, rd_odd_reg} : {rd_odd_reg, rd_even_reg};
    assign shamt = {1'b0, lane_reg, 3'b000};

    always_comb
    begin
        unique case (op_reg)
            blsu_pkg::OP_LB, blsu_pkg::OP_LBU, blsu_pkg::OP_SB: wmask = 64'h0000_0000_0000_00FF;
            blsu_pkg::OP_LH, blsu_pkg::OP_LHU, blsu_pkg::OP_SH: wmask = 64'h0000_0000_0000_FFFF;
            default:                                            wmask = 64'h0000_0000_FFFF_FFFF;
        endcase
    end

    assign shifted  = pair >> shamt;
    assign new_pair = (pair & ~(wmask << shamt)) | (({32'd0, sdata_reg} & wmask) << shamt);

    always_comb
    begin
        load_val = shifted[31:0] & wmask[31:0];
        if (op_reg == blsu_pkg::OP_LB && load_val[7])
            load_val = load_val | 32'hFFFF_FF00;
        else if (op_reg == blsu_pkg::OP_LH && load_val[15])
            load_val = load_val | 32'hFFFF_0000;
    end

    // state machine, bank writes and result register
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        we_even       = 1'b0;
        we_odd        = 1'b0;
        wa_even       = addr_even_reg;
        wa_odd        = addr_odd_reg;
        wd_even       = odd_first_reg ? new_pair[63:32] : new_pair[31:0];
        wd_odd        = odd_first_reg ? new_pair[31:0]  : new_pair[63:32];

        unique case (state_reg)
            blsu_pkg::ST_CLEAR:
            begin
                we_even = 1'b1;
                we_odd  = ({1'b0, clr_addr_reg} < (AW + 1)'(blsu_pkg::BANK_ODD_DEPTH));
                wa_even = clr_addr_reg;
                wa_odd  = clr_addr_reg;
                wd_even = 32'd0;
                wd_odd  = 32'd0;
                if ({1'b0, clr_addr_reg} == (AW + 1)'(blsu_pkg::BANK_EVEN_DEPTH - 1))
                    state_next = blsu_pkg::ST_IDLE;
                else
                    clr_addr_next = clr_addr_reg + AW'(1);
            end
            blsu_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = blsu_pkg::ST_EXEC;
            end
            blsu_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    if (is_store && !err_reg)
                    begin
                        we_even = odd_first_reg ? split_reg : 1'b1;
                        we_odd  = odd_first_reg ? 1'b1 : split_reg;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, err_reg,
                                     (is_store || err_reg) ? 32'd0 : load_val};
                    state_next    = blsu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blsu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= blsu_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        if (accept)
        begin
            op_reg        <= in_op;
            lane_reg      <= in_lane;
            odd_first_reg <= in_idx[0];
            split_reg     <= in_split;
            err_reg       <= in_err;
            sdata_reg     <= in_sdata;
            addr_even_reg <= in_addr_even;
            addr_odd_reg  <= in_base;
        end
    end

    // even bank
    always_ff @(posedge clk)
    begin
        if (we_even)
            mem_even[wa_even] <= wd_even;
        if (accept)
            rd_even_reg <= mem_even[in_addr_even];
    end

    // odd bank
    always_ff @(posedge clk)
    begin
        if (we_odd)
            mem_odd[wa_odd] <= wd_odd;
        if (accept)
            rd_odd_reg <= mem_odd[in_base];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking stream testbench for the byte addressed load/store unit
module tb_top;

    import blsu_pkg::*;

    localparam logic [31:0] BYTE_SPAN    = MEM_WORDS * 4;
    localparam int          RANDOM_WORDS = 317;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [31:0] load_data;
        logic        access_error;
    } access_result_t;

    // one directed access; known marks a row whose result is typed in
    typedef struct packed {
        op_t         op;
        logic [31:0] address;
        logic [31:0] store_data;
        logic        known;
        logic [31:0] load_data;
        logic        access_error;
    } access_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [31:0]    model_words [MEM_WORDS];
    access_result_t pending_results [$];
    int             fail_count = 0;
    int             cycle_count = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;

    access_row_t directed_rows [24] = '{
        '{OP_LW,  32'h0000_0000,   32'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{OP_LBU, BYTE_SPAN - 1,   32'h0000_0000, 1'b1, 32'h0, 1'b0},
        '{OP_SW,  32'h0000_0000,   32'hDEAD_BEEF, 1'b1, 32'h0, 1'b0},
        '{OP_LW,  32'h0000_0000,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_LB,  32'h0000_0003,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_LBU, 32'h0000_0003,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_LH,  32'h0000_0002,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_LHU, 32'h0000_0002,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_SH,  32'h0000_0003,   32'h1234_A5C6, 1'b1, 32'h0, 1'b0},
        '{OP_LH,  32'h0000_0003,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_LHU, 32'h0000_0003,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_SW,  32'h0000_0005,   32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
        '{OP_LW,  32'h0000_0006,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_SB,  BYTE_SPAN - 4,   32'h0000_0080, 1'b1, 32'h0, 1'b0},
        '{OP_LB,  BYTE_SPAN - 4,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_SW,  BYTE_SPAN - 3,   32'h1122_3344, 1'b1, 32'h0, 1'b1},
        '{OP_LW,  BYTE_SPAN - 2,   32'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{OP_LH,  BYTE_SPAN - 1,   32'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{OP_LHU, BYTE_SPAN - 1,   32'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{OP_SB,  BYTE_SPAN,       32'h0000_00FF, 1'b1, 32'h0, 1'b1},
        '{OP_LW,  32'hFFFF_FFFF,   32'h0000_0000, 1'b1, 32'h0, 1'b1},
        '{OP_SH,  BYTE_SPAN - 2,   32'hFFFF_8001, 1'b1, 32'h0, 1'b0},
        '{OP_LH,  BYTE_SPAN - 2,   32'h0000_0000, 1'b0, 32'h0, 1'b0},
        '{OP_LBU, 32'h0000_0001,   32'h0000_0000, 1'b0, 32'h0, 1'b0}
    };

    byte_addressed_load_store_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // performs one access on the word store copy and returns what the unit should give back
    function automatic access_result_t apply_access(op_t op, logic [31:0] addr,
                                                    logic [31:0] sdata);
        logic [31:0]    idx0;
        logic [32:0]    idx1;
        int unsigned    lane;
        int unsigned    nbytes;
        int unsigned    shift;
        logic           split;
        logic [63:0]    pair;
        logic [63:0]    wmask;
        logic [63:0]    lane_mask;
        logic [31:0]    value;
        access_result_t res;
        idx0   = {2'b00, addr[31:2]};
        idx1   = {1'b0, idx0} + 33'd1;
        lane   = addr[1:0];
        nbytes = (op inside {OP_LB, OP_LBU, OP_SB}) ? 1 :
                 (op inside {OP_LH, OP_LHU, OP_SH}) ? 2 : 4;
        split  = (lane + nbytes) > 4;
        res.load_data    = '0;
        res.access_error = (idx0 >= MEM_WORDS) || (split && idx1 >= MEM_WORDS);
        if (!res.access_error)
        begin
            shift = lane * 8;
            wmask = (nbytes == 4) ? 64'hFFFF_FFFF : (nbytes == 2) ? 64'hFFFF : 64'hFF;
            pair  = {32'h0, model_words[idx0]};
            if (split)
                pair[63:32] = model_words[idx1];
            if (op inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU})
            begin
                value = 32'((pair >> shift) & wmask);
                if (op == OP_LB && value[7])
                    value[31:8] = '1;
                else if (op == OP_LH && value[15])
                    value[31:16] = '1;
                res.load_data = value;
            end
            else
            begin
                lane_mask = wmask << shift;
                pair = (pair & ~lane_mask) | (({32'h0, sdata} & wmask) << shift);
                model_words[idx0] = pair[31:0];
                if (split)
                    model_words[idx1] = pair[63:32];
            end
        end
        return res;
    endfunction

    // mostly low bytes (loads hit earlier stores), else whole store, top edge, any address
    function automatic logic [31:0] pick_address();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 63);
        else if (r < 80)
            return $urandom_range(0, BYTE_SPAN - 1);
        else if (r < 94)
            return BYTE_SPAN - 8 + $urandom_range(0, 15);
        return $urandom;
    endfunction

    task automatic issue_access(op_t op, logic [31:0] addr, logic [31:0] sdata,
                                logic known, access_result_t known_result);
        access_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, sdata, addr, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = apply_access(op, addr, sdata);
        pending_results.push_back(known ? known_result : predicted);
    endtask

    task automatic compare_result(logic [M_TDATA_W-1:0] word);
        access_result_t wanted;
        if (pending_results.size() == 0)
        begin
            $error("result word %h with nothing outstanding", word);
            fail_count++;
        end
        else
        begin
            wanted = pending_results.pop_front();
            if (word[31:0] !== wanted.load_data)
            begin
                $error("load_data: expected %h, actual %h", wanted.load_data, word[31:0]);
                fail_count++;
            end
            if (word[32] !== wanted.access_error)
            begin
                $error("access_error: expected %b, actual %b", wanted.access_error, word[32]);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            compare_result(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        access_result_t row_result;
        for (int i = 0; i < MEM_WORDS; i++)
            model_words[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 86 : 0;
            recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 21 : 0;
            if (phase == 0)
            begin
                foreach (directed_rows[i])
                begin
                    row_result.load_data    = directed_rows[i].load_data;
                    row_result.access_error = directed_rows[i].access_error;
                    issue_access(directed_rows[i].op, directed_rows[i].address,
                                 directed_rows[i].store_data, directed_rows[i].known,
                                 row_result);
                end
            end
            row_result = '0;
            for (int n = 0; n < RANDOM_WORDS; n++)
                issue_access(op_t'($urandom_range(0, 7)), pick_address(), $urandom,
                             1'b0, row_result);
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // keep clocking to catch any stray result word
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
